>>> src/bkta_pkg.sv
// bkta_pkg: shared constants, register codes and control types for the
// best-k timing averager. No dependencies.
`timescale 1ns / 1ps
package bkta_pkg;

  localparam int KEEP_COUNT_DEF = 10;
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [7:0]  TOL_RESET   = 8'd51;
  localparam logic [31:0] LIMIT_RESET = 32'd900000000;

  // register index, taken from paddr[2]
  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [3:0] KEPT_SAT = 4'd15;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> src/bkta_cell.sv
// bkta_cell: one slot of the sorted ring of kept samples.
// Depends on bkta_pkg (cell_ctrl_t).
`timescale 1ns / 1ps
module bkta_cell
  import bkta_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [TIME_WIDTH-1:0] sample,
  input  logic [TIME_WIDTH-1:0] prev_val,
  input  logic                  prev_gt,
  output logic [TIME_WIDTH-1:0] val,
  output logic                  gt
);

  logic [TIME_WIDTH-1:0] val_r;

  assign val = val_r;
  assign gt  = sample < val_r;

  // insert: slots above the insertion point take their neighbour's entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '1;
    end else if (ctrl.insert) begin
      if (gt) begin
        val_r <= prev_gt ? prev_val : sample;
      end
    end else if (ctrl.rotate) begin
      val_r <= prev_val;
    end
  end

endmodule

>>> src/bkta_divider.sv
// bkta_divider: restoring divider, one quotient bit per cycle.
// Depends on bkta_pkg (div_stat_t).
`timescale 1ns / 1ps
module bkta_divider
  import bkta_pkg::*;
#(
  parameter int SUM_W = 36,
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    shifted;
  logic              ge;

  assign shifted  = {rem_r, quo_r[SUM_W-1]};
  assign ge       = shifted >= {1'b0, div_r};
  assign quotient = quo_r;
  assign stat     = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? CNT_W'(shifted - {1'b0, div_r}) : shifted[CNT_W-1:0];
        quo_r  <= {quo_r[SUM_W-2:0], ge};
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/best_k_timing_averager.sv
// best_k_timing_averager: top level; ring of sample cells, scan accumulator,
// serial divider and APB register file. Depends on bkta_pkg, bkta_cell, bkta_divider.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one time_sample per beat (tdata[31:0]).
//   out_* : one result beat per sample; tuser = rejected,
//           tdata[31:0] = average_time, tdata[35:32] = kept_count.
//   cfg_* : APB, 0x0 tolerance_frac (8 bits), 0x4 valid_limit (32 bits).
// Each sample runs: band multiply, compare, insert into the cell ring (accepted
// samples only), then a full rotation of the ring to sum and count the entries
// below valid_limit, then the restoring divider, which shifts out the quotient
// bit by bit. The divider is skipped for a rejected sample and for an accepted
// one with no entry counted. in_tready rises as the result is loaded into the
// output register.
// One sample is in flight at a time; in_tready is high while idle, also when a
// result is still waiting on out_tready. A finished item waits in its last state
// until the output register is free, so a stalled receiver holds off the next one.
// Reset (synchronous, rst_n low) empties all slots to all ones, clears the
// average, and restores the register defaults.
module best_k_timing_averager
  import bkta_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] time_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [31:0] average_time, [35:32] kept_count, zero pad
  output logic        out_tuser,    // [0] rejected
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W  = $clog2(KEEP_COUNT + 1);
  localparam int SUM_W  = TIME_WIDTH + CNT_W;
  localparam int SCAN_W = $clog2(KEEP_COUNT);
  localparam int CMP_W  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int KW     = (CNT_W > 4) ? CNT_W : 4;
  localparam int PW     = TIME_WIDTH + 9;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CMP, S_INSERT, S_SCAN, S_DIV, S_DONE
  } state_t;

  state_t                state_r;
  logic [7:0]            tol_r;
  logic [31:0]           limit_r;
  logic [TIME_WIDTH-1:0] sample_r;
  logic [TIME_WIDTH-1:0] avg_r;
  logic                  have_avg_r;
  logic [PW-1:0]         upper_r;
  logic [PW-1:0]         lower_r;
  logic                  reject_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [SCAN_W-1:0]     scan_r;
  logic [CNT_W-1:0]      kept_r;
  logic                  out_valid_r;
  logic                  out_rej_r;
  logic [31:0]           out_avg_r;
  logic [3:0]            out_kept_r;

  logic                  in_fire;
  logic                  cfg_wr;
  logic [TIME_WIDTH-1:0] in_time;
  logic [PW-1:0]         scaled;
  logic                  scan_last;
  logic                  counted;
  logic                  div_start;
  logic                  out_free;
  logic [KW-1:0]         kept_ext;
  logic [CMP_W-1:0]      avg_ext;
  cell_ctrl_t            ctrl;
  div_stat_t             div_stat;
  logic [SUM_W-1:0]      quotient;

  logic [TIME_WIDTH-1:0] cell_val [KEEP_COUNT];
  logic                  cell_gt  [KEEP_COUNT];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_time   = TIME_WIDTH'(in_tdata);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[2])
      REG_TOL:   cfg_prdata = {24'd0, tol_r};
      REG_LIMIT: cfg_prdata = limit_r;
      default:   cfg_prdata = '0;
    endcase
  end

  assign ctrl = '{insert: (state_r == S_INSERT), rotate: (state_r == S_SCAN)};

  for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_cell
    if (g == 0) begin : g_head
      bkta_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk, .rst_n, .ctrl, .sample(sample_r),
        .prev_val(cell_val[KEEP_COUNT-1]), .prev_gt(1'b0),
        .val(cell_val[g]), .gt(cell_gt[g])
      );
    end else begin : g_body
      bkta_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
        .clk, .rst_n, .ctrl, .sample(sample_r),
        .prev_val(cell_val[g-1]), .prev_gt(cell_gt[g-1]),
        .val(cell_val[g]), .gt(cell_gt[g])
      );
    end
  end

  // tail slot is read once per rotation step
  assign counted   = CMP_W'(cell_val[KEEP_COUNT-1]) < CMP_W'(limit_r);
  assign sum_nxt   = counted ? sum_r + SUM_W'(cell_val[KEEP_COUNT-1]) : sum_r;
  assign cnt_nxt   = counted ? cnt_r + 1'b1 : cnt_r;
  assign scan_last = (scan_r == SCAN_W'(KEEP_COUNT - 1));
  assign div_start = (state_r == S_SCAN) && scan_last && !reject_r && (cnt_nxt != '0);
  assign scaled    = {sample_r, 8'd0};
  assign out_free  = !out_valid_r || out_tready;
  assign kept_ext  = KW'(kept_r);
  assign avg_ext   = CMP_W'(avg_r);

  bkta_divider #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(sum_nxt), .divisor(cnt_nxt),
    .stat(div_stat), .quotient
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_TOL:   tol_r   <= cfg_pwdata[7:0];
        REG_LIMIT: limit_r <= cfg_pwdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      avg_r       <= '0;
      have_avg_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            sample_r <= in_time;
            if (!have_avg_r) begin
              avg_r      <= in_time;
              have_avg_r <= 1'b1;
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          upper_r <= PW'(avg_r) * PW'(9'd256 + {1'b0, tol_r});
          lower_r <= PW'(avg_r) * PW'(9'd256 - {1'b0, tol_r});
          state_r <= S_CMP;
        end
        S_CMP: begin
          reject_r <= (scaled > upper_r) || (scaled < lower_r);
          sum_r    <= '0;
          cnt_r    <= '0;
          scan_r   <= '0;
          state_r  <= ((scaled > upper_r) || (scaled < lower_r)) ? S_SCAN : S_INSERT;
        end
        S_INSERT: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          sum_r  <= sum_nxt;
          cnt_r  <= cnt_nxt;
          scan_r <= scan_r + 1'b1;
          if (scan_last) begin
            kept_r  <= cnt_nxt;
            state_r <= div_start ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            avg_r   <= quotient[TIME_WIDTH-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rej_r   <= reject_r;
            out_avg_r   <= avg_ext[31:0];
            out_kept_r  <= (kept_ext > KW'(KEPT_SAT)) ? KEPT_SAT : kept_ext[3:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rej_r;
  assign out_tdata  = {4'd0, out_kept_r, out_avg_r};

endmodule

>>> src/bkta_checker.sv
// bkta_checker: port-level assertions for best_k_timing_averager, bound to the top.
// Depends on bkta_pkg (KEEP_COUNT_DEF).
`timescale 1ns / 1ps
module bkta_checker
  import bkta_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  localparam logic [6:0] KEPT_LIMIT = (KEEP_COUNT > 15) ? 7'd15 : 7'(KEEP_COUNT);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one sample in flight: the beat after an accepted input is never taken at once
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // if out_tvalid is low when an input is taken, it stays low in S_MUL and S_CMP
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid ##1 !out_tvalid)
    else $error("result appeared too early");

  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {3'd0, out_tdata[35:32]} <= KEPT_LIMIT)
    else $error("kept_count exceeds slot count");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind best_k_timing_averager bkta_checker #(.KEEP_COUNT(KEEP_COUNT)) u_bkta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> sim/tb_top.sv
// tb_top: self-checking bench for best_k_timing_averager; drives sample beats, programs
// the APB registers and checks every result beat against a local model of the block.
// Depends on bkta_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  import bkta_pkg::*;

  localparam int SLOTS         = KEEP_COUNT_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int IDLE_LIMIT    = 3000;

  typedef struct packed {
    logic        rejected;
    logic [31:0] average;
    logic [3:0]  kept;
  } summary_t;

  typedef enum {
    PICK_FIXED, PICK_MIX, PICK_NOISE, PICK_TOP, PICK_OVER, PICK_BOTTOM, PICK_UNDER, PICK_MEAN
  } pick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [31:0] best_m [SLOTS];
  logic [31:0] avg_m;
  logic        have_m;
  logic [7:0]  tol_m;
  logic [31:0] limit_m;

  logic [31:0] sample_queue [$];
  summary_t    awaited_summaries [$];
  int          errors = 0;
  int          gap_left = 0;
  int          burst_left = 1;
  int          stall_left = 0;
  int          stall_mode = 0;
  int          idle_cycles = 0;

  best_k_timing_averager dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [31:0] time_sample
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [31:0] average_time, [35:32] kept_count, zero pad
    .out_tuser   (out_tuser),    // [0] rejected
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [39:0] got,
                               input logic [39:0] want);
    if (errors < 50)
      $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // band test, insert and recount for one accepted sample beat
  task automatic absorb_sample(input logic [31:0] t);
    logic [63:0] scaled, upper, lower, total;
    logic        reject;
    int          pos, n, k;
    summary_t    r;
    if (!have_m) begin
      avg_m = t;
      have_m = 1'b1;
    end
    scaled = 64'(t) << 8;
    upper = 64'(avg_m) * (64'd256 + 64'(tol_m));
    lower = 64'(avg_m) * (64'd256 - 64'(tol_m));
    reject = (scaled > upper) || (scaled < lower);
    if (!reject) begin
      pos = SLOTS;
      for (k = SLOTS - 1; k >= 0; k--)
        if (t < best_m[k]) pos = k;
      if (pos < SLOTS) begin
        for (k = SLOTS - 1; k > pos; k--) best_m[k] = best_m[k - 1];
        best_m[pos] = t;
      end
    end
    total = '0;
    n = 0;
    for (k = 0; k < SLOTS; k++)
      if (best_m[k] < limit_m) begin
        total += 64'(best_m[k]);
        n++;
      end
    if (!reject && n != 0) avg_m = 32'(total / 64'(n));
    r.rejected = reject;
    r.average = avg_m;
    r.kept = (n > 15) ? KEPT_SAT : 4'(n);
    awaited_summaries.push_back(r);
  endtask

  // sample placed against the current band: edges, inside, outside or noise
  function automatic logic [31:0] pick(input pick_t mode);
    logic [63:0] top, bottom;
    pick_t       m;
    int unsigned sel;
    logic [31:0] v;
    top = (64'(avg_m) * (64'd256 + 64'(tol_m))) >> 8;
    bottom = (64'(avg_m) * (64'd256 - 64'(tol_m)) + 64'd255) >> 8;
    if (top > 64'hFFFF_FFFE) top = 64'hFFFF_FFFE;
    m = mode;
    if (mode == PICK_MIX) begin
      sel = $urandom_range(99);
      if (sel < 12) m = PICK_NOISE;
      else if (sel < 16) m = PICK_OVER;
      else if (sel < 20) m = PICK_TOP;
      else if (sel < 24) m = PICK_BOTTOM;
      else if (sel < 28) m = PICK_UNDER;
      else if (sel < 32) m = PICK_MEAN;
    end
    case (m)
      PICK_NOISE:  v = $urandom;
      PICK_TOP:    v = top[31:0];
      PICK_OVER:   v = (top < 64'hFFFF_FFFE) ? 32'(top + 1) : top[31:0];
      PICK_BOTTOM: v = bottom[31:0];
      PICK_UNDER:  v = (bottom == 0) ? 32'd0 : 32'(bottom - 1);
      PICK_MEAN:   v = avg_m;
      default: begin
        if (sel < 66) v = (top < 64'(avg_m)) ? top[31:0] :
                          avg_m + $urandom_range(32'(top - 64'(avg_m)));
        else v = avg_m - $urandom_range(32'((64'(avg_m) - bottom) >> 2));
      end
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return 0;
    if (sel < 7) return $urandom_range(1, 8);
    return $urandom_range(9, 90);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_sample(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= sample_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= pick_gap();
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    summary_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_summaries.size() == 0) begin
          flag_mismatch("unexpected beat", out_tdata, '0);
        end else begin
          want = awaited_summaries.pop_front();
          if (out_tuser !== want.rejected)
            flag_mismatch("rejected", 40'(out_tuser), 40'(want.rejected));
          if (out_tdata[31:0] !== want.average)
            flag_mismatch("average_time", 40'(out_tdata[31:0]), 40'(want.average));
          if (out_tdata[35:32] !== want.kept)
            flag_mismatch("kept_count", 40'(out_tdata[35:32]), 40'(want.kept));
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(2);
        stall_left <= $urandom_range(50, 400);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(1));
        default: out_tready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_sel == REG_TOL) tol_m = value[7:0];
    else limit_m = value;
  endtask

  task automatic retune(input logic [7:0] tol, input logic [31:0] limit);
    write_reg(REG_TOL, 32'(tol));
    write_reg(REG_LIMIT, limit);
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_tvalid || awaited_summaries.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one beat at a time, so each pick sees the state after the previous beat
  task automatic send(input pick_t mode, input logic [31:0] fixed);
    do @(negedge clk); while (sample_queue.size() != 0 || in_tvalid);
    sample_queue.push_back(mode == PICK_FIXED ? fixed : pick(mode));
  endtask

  task automatic send_mixed(input int count);
    repeat (count) send(PICK_MIX, '0);
  endtask

  initial begin
    for (int k = 0; k < SLOTS; k++) best_m[k] = '1;
    avg_m = '0;
    have_m = 1'b0;
    tol_m = TOL_RESET;
    limit_m = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // first sample all ones: sets the average, never stored, nothing counts
    send(PICK_FIXED, 32'hFFFF_FFFF);
    send(PICK_FIXED, 32'hFFFF_FFFE);
    send(PICK_FIXED, 32'hD000_0000);
    send(PICK_FIXED, 32'h0000_0000);
    send(PICK_FIXED, 32'hCC00_0000);
    send(PICK_BOTTOM, '0);
    send(PICK_UNDER, '0);

    drain_all();
    retune(8'd255, LIMIT_RESET);
    send(PICK_BOTTOM, '0);
    send(PICK_MEAN, '0);
    send(PICK_TOP, '0);
    send(PICK_OVER, '0);
    send(PICK_UNDER, '0);
    send(PICK_BOTTOM, '0);
    send(PICK_MEAN, '0);
    send(PICK_FIXED, 32'h0000_0000);
    send(PICK_FIXED, 32'hFFFF_FFFE);
    send_mixed(8);

    drain_all();
    retune(8'd51, 32'hFFFF_FFFF);
    send_mixed(300);
    drain_all();
    retune(8'd0, avg_m + 32'd1);
    send_mixed(150);
    drain_all();
    retune(8'd128, 32'd0);
    send_mixed(150);
    drain_all();
    retune(8'($urandom), avg_m);
    send_mixed(300);
    drain_all();
    retune(8'd255, 32'hFFFF_FFFF);
    send_mixed(300);
    drain_all();
    retune(8'($urandom), $urandom);
    send_mixed(300);

    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> best_k_timing_averager.f
src/bkta_pkg.sv
src/bkta_cell.sv
src/bkta_divider.sv
src/best_k_timing_averager.sv
src/bkta_checker.sv
sim/tb_top.sv
